// File: src/htw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants of the timer table: item kinds, field widths
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int unsigned TIMERS_DEF  = 32;
  localparam int unsigned MAX_FIRES   = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ID_W        = 5;
  localparam int unsigned AMOUNT_W    = 31;
  localparam int unsigned TICK_W      = 32;

  typedef enum logic [KIND_W-1:0] {
    KindTick = 2'd0,
    KindAdd  = 2'd1,
    KindDel  = 2'd2,
    KindAdj  = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the input item, advance the counter for tick/adjust
    logic resp;    // answer add, delete or zero adjust
    logic scan;    // walk the timer table
    logic fin;     // close a tick/adjust with its final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_item;  // the offered item needs a table scan
    logic scan_done;
    logic out_free;   // the result register can take a new result
  } sts_t;

endpackage
`default_nettype wire

// File: src/htw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htw_in_if
// Request channel of the timer table: one operation per item.
// ----------------------------------------------------------------------------
interface htw_in_if;
  logic                         valid;
  logic                         ready;
  logic [htw_pkg::KIND_W-1:0]   kind;
  logic [htw_pkg::ID_W-1:0]     timer_id;
  logic [htw_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, kind, timer_id, amount, input ready);
  modport sink   (input valid, kind, timer_id, amount, output ready);
endinterface
`default_nettype wire

// File: src/htw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htw_out_if
// Result channel of the timer table: one or more items per request.
// ----------------------------------------------------------------------------
interface htw_out_if;
  logic                       valid;
  logic                       ready;
  logic [htw_pkg::KIND_W-1:0] done_kind;
  logic                       status;
  logic                       triggered_before;
  logic                       fired;
  logic [htw_pkg::ID_W-1:0]   fired_id;
  logic [htw_pkg::TICK_W-1:0] current_tick;
  logic                       last;

  modport source (output valid, done_kind, status, triggered_before, fired, fired_id,
                  current_tick, last, input ready);
  modport sink   (input valid, done_kind, status, triggered_before, fired, fired_id,
                  current_tick, last, output ready);
endinterface
`default_nettype wire

// File: src/htw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer of the timer table: accepts an item, then either answers it
// directly or runs the table scan and closes it with the final result.
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire htw_pkg::sts_t sts_i,
  output htw_pkg::cmd_t      cmd_o
);
  import htw_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StResp,
    StScan,
    StFin
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.scan_item ? StScan : StResp;
        end
      end
      StResp: begin
        cmd_o.resp = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: src/htw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htw_datapath
// Tick counter, timer flags, deadline memory, scan pointer and the result
// register. Firing is reported one step late so the final fired timer can
// carry the last flag.
// ----------------------------------------------------------------------------
module htw_datapath #(
  parameter int unsigned Timers = htw_pkg::TIMERS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire htw_pkg::cmd_t                cmd_i,
  output htw_pkg::sts_t                     sts_o,
  input  wire logic [htw_pkg::KIND_W-1:0]   in_kind_i,
  input  wire logic [htw_pkg::ID_W-1:0]     in_timer_id_i,
  input  wire logic [htw_pkg::AMOUNT_W-1:0] in_amount_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [htw_pkg::KIND_W-1:0]        out_done_kind_o,
  output logic                              out_status_o,
  output logic                              out_triggered_before_o,
  output logic                              out_fired_o,
  output logic [htw_pkg::ID_W-1:0]          out_fired_id_o,
  output logic [htw_pkg::TICK_W-1:0]        out_current_tick_o,
  output logic                              out_last_o
);
  import htw_pkg::*;

  localparam int IW  = (Timers > 1) ? $clog2(Timers) : 1;
  localparam int CW  = $clog2(Timers + 1);
  localparam int FCW = $clog2(MAX_FIRES + 1);
  localparam int XW  = 7;  // wide enough to compare any id against the table size

  // latched item
  kind_e                kind_q;
  logic [ID_W-1:0]      id_q;
  logic [AMOUNT_W-1:0]  amt_q;

  logic [TICK_W-1:0]    now_q, base_q;
  logic [Timers-1:0]    queued_q, trig_q;

  // scan pipeline
  logic [CW-1:0]        ra_q;
  logic                 ev_q;
  logic [IW-1:0]        ei_q;
  logic                 hold_v_q;
  logic [IW-1:0]        hold_id_q;
  logic [FCW-1:0]       cnt_q;

  logic [TICK_W-1:0]    dl_mem [Timers];
  logic [TICK_W-1:0]    rd_q;

  // result register
  logic                 out_valid_q;
  logic [KIND_W-1:0]    res_kind_q;
  logic                 res_status_q, res_trig_q, res_fired_q, res_last_q;
  logic [ID_W-1:0]      res_id_q;
  logic [TICK_W-1:0]    res_tick_q;

  kind_e                in_kind;
  logic                 out_free;
  logic [TICK_W-1:0]    d_base, d_now;
  logic                 clamp, due, q_sel, fire_now, stall, adv;
  logic                 rd_en, clamp_wr, add_wr, wr_en;
  logic [IW-1:0]        wr_addr;
  logic [TICK_W-1:0]    wr_data;
  logic                 id_ok;
  logic [IW-1:0]        id_idx;
  logic                 emit_hold;

  assign in_kind  = kind_e'(in_kind_i);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.scan_item = (in_kind == KindTick) ||
                           ((in_kind == KindAdj) && (in_amount_i != '0));
  assign sts_o.scan_done = (ra_q == CW'(Timers)) && !ev_q;
  assign sts_o.out_free  = out_free;

  // due test of the entry under evaluation; for adjust the clamp decides too
  assign d_base = rd_q - base_q;
  assign d_now  = rd_q - now_q;
  assign clamp  = (kind_q == KindAdj) && (d_base[TICK_W-1] ||
                  (d_base[TICK_W-2:0] < amt_q));
  always_comb begin
    if (kind_q == KindAdj) begin
      due = clamp || (d_base == {1'b0, amt_q});
    end else begin
      due = (d_now == '0) || d_now[TICK_W-1];
    end
  end

  assign q_sel     = queued_q[ei_q];
  assign fire_now  = ev_q && q_sel && due && (cnt_q < FCW'(MAX_FIRES));
  assign stall     = fire_now && hold_v_q && !out_free;
  assign adv       = cmd_i.scan && !stall;
  assign emit_hold = adv && fire_now && hold_v_q;
  assign rd_en     = adv && (ra_q < CW'(Timers));

  assign id_ok  = XW'(id_q) < XW'(Timers);
  assign id_idx = IW'(id_q);

  assign clamp_wr = adv && ev_q && q_sel && clamp;
  assign add_wr   = cmd_i.resp && (kind_q == KindAdd) && id_ok;
  assign wr_en    = clamp_wr || add_wr;
  assign wr_addr  = clamp_wr ? ei_q : id_idx;
  assign wr_data  = clamp_wr ? now_q : (now_q + TICK_W'(amt_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= dl_mem[ra_q[IW-1:0]];
    end
  end

  // item latch and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_kind;
      id_q   <= in_timer_id_i;
      amt_q  <= in_amount_i;
      base_q <= now_q;
    end
    if (adv) begin
      ei_q <= ra_q[IW-1:0];
    end
    if (adv && fire_now) begin
      hold_id_q <= ei_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      queued_q <= '0;
      trig_q   <= '0;
      ra_q     <= '0;
      ev_q     <= 1'b0;
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        ra_q     <= '0;
        ev_q     <= 1'b0;
        hold_v_q <= 1'b0;
        cnt_q    <= '0;
        if (in_kind == KindTick) begin
          now_q <= now_q + TICK_W'(1);
        end else if (in_kind == KindAdj) begin
          now_q <= now_q + TICK_W'(in_amount_i);
        end
      end
      if (adv) begin
        ev_q <= rd_en;
        if (rd_en) begin
          ra_q <= ra_q + CW'(1);
        end
        if (fire_now) begin
          queued_q[ei_q] <= 1'b0;
          trig_q[ei_q]   <= 1'b1;
          hold_v_q       <= 1'b1;
          cnt_q          <= cnt_q + FCW'(1);
        end
      end
      if (cmd_i.resp && id_ok) begin
        if (kind_q == KindAdd) begin
          queued_q[id_idx] <= 1'b1;
          trig_q[id_idx]   <= 1'b0;
        end else if (kind_q == KindDel) begin
          queued_q[id_idx] <= 1'b0;
          trig_q[id_idx]   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp || cmd_i.fin || emit_hold) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      res_kind_q  <= kind_q;
      res_fired_q <= 1'b0;
      res_id_q    <= '0;
      res_tick_q  <= now_q;
      res_last_q  <= 1'b1;
      res_trig_q  <= id_ok && (kind_q == KindAdd || kind_q == KindDel) && trig_q[id_idx];
      if (id_ok && kind_q == KindAdd) begin
        res_status_q <= !queued_q[id_idx];
      end else if (id_ok && kind_q == KindDel) begin
        res_status_q <= queued_q[id_idx];
      end else begin
        res_status_q <= 1'b0;
      end
    end else if (emit_hold || cmd_i.fin) begin
      // a held fire goes out; at the close it is the last one, or no timer fired
      res_kind_q   <= kind_q;
      res_status_q <= hold_v_q;
      res_trig_q   <= 1'b0;
      res_fired_q  <= hold_v_q;
      res_id_q     <= hold_v_q ? ID_W'(hold_id_q) : '0;
      res_tick_q   <= now_q;
      res_last_q   <= cmd_i.fin;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_done_kind_o        = res_kind_q;
  assign out_status_o           = res_status_q;
  assign out_triggered_before_o = res_trig_q;
  assign out_fired_o            = res_fired_q;
  assign out_fired_id_o         = res_id_q;
  assign out_current_tick_o     = res_tick_q;
  assign out_last_o             = res_last_q;

endmodule
`default_nettype wire

// File: src/hierarchical_timer_wheel_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_core
// Timer table with a wrapping tick counter: add, delete, tick and adjust.
// ----------------------------------------------------------------------------
// One item at a time. Add, delete and an adjust by zero give one result. A tick
// or a nonzero adjust runs a scan of the table: the deadline memory has a single
// read port and the scan reads one entry per cycle unless the result channel
// stalls it, evaluating the previous one in the same cycle. Every expired timer
// is reported in its own result in ascending id order, at most 32 per item; a
// scan that fires nothing gives one result with fired low. Back-pressure on the
// result channel pauses the scan. A new item is taken once the previous one has
// its final result in the output register.
module hierarchical_timer_wheel_core #(
  parameter int unsigned Timers = htw_pkg::TIMERS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  htw_in_if.sink    in_i,
  htw_out_if.source out_o
);
  import htw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  htw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htw_datapath #(
    .Timers (Timers)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .in_kind_i              (in_i.kind),
    .in_timer_id_i          (in_i.timer_id),
    .in_amount_i            (in_i.amount),
    .out_ready_i            (out_o.ready),
    .out_valid_o            (out_o.valid),
    .out_done_kind_o        (out_o.done_kind),
    .out_status_o           (out_o.status),
    .out_triggered_before_o (out_o.triggered_before),
    .out_fired_o            (out_o.fired),
    .out_fired_id_o         (out_o.fired_id),
    .out_current_tick_o     (out_o.current_tick),
    .out_last_o             (out_o.last)
  );

endmodule
`default_nettype wire
